[hdl/rrr_pkg.sv]
package rrr_pkg;

  // Width of one slice of a wide multiplier operand
  localparam int LIMB_W = 16;

  // Number of slices needed to cover a value of the given width
  function automatic int nlimbs(input int bits);
    return (bits + LIMB_W - 1) / LIMB_W;
  endfunction

endpackage

[hdl/rrr_if.sv]
interface rrr_in_if #(
  parameter int VOLUME_BITS = 40
) ();
  logic                   valid;
  logic                   ready;
  logic [VOLUME_BITS-1:0] storage;
  logic [VOLUME_BITS-1:0] inflow;
  logic [VOLUME_BITS-1:0] demand;
  logic [VOLUME_BITS-1:0] capacity;
  logic [VOLUME_BITS-1:0] mean_inflow;
  logic [VOLUME_BITS-1:0] mean_demand;
  logic                   is_irrigation;

  modport source (
    output valid, storage, inflow, demand, capacity, mean_inflow, mean_demand,
           is_irrigation,
    input  ready
  );
  modport sink (
    input  valid, storage, inflow, demand, capacity, mean_inflow, mean_demand,
           is_irrigation,
    output ready
  );
endinterface

interface rrr_out_if #(
  parameter int VOLUME_BITS = 40
) ();
  logic                   valid;
  logic                   ready;
  logic [VOLUME_BITS+1:0] release_res;
  logic                   saturated;
  logic                   divide_by_zero;

  modport source (
    output valid, release_res, saturated, divide_by_zero,
    input  ready
  );
  modport sink (
    input  valid, release_res, saturated, divide_by_zero,
    output ready
  );
endinterface

[hdl/rrr_divstep.sv]
module rrr_divstep #(
  parameter int W = 8
) (
  input  logic [W-1:0] rem_i,
  input  logic         bit_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] rem_o,
  output logic         q_o
);

  logic [W:0] sh;

  // Shift in one dividend bit, subtract the divisor when it fits
  assign sh    = {rem_i, bit_i};
  assign q_o   = (sh >= {1'b0, den_i});
  assign rem_o = q_o ? W'(sh - {1'b0, den_i}) : sh[W-1:0];

endmodule

[hdl/rrr_skid.sv]
module rrr_skid #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [DW-1:0] in_data_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output logic [DW-1:0] out_data_o,
  input  logic          out_ready_i
);

  logic          out_v_q, out_v_d;
  logic          sp_v_q, sp_v_d;
  logic [DW-1:0] out_data_q, sp_data_q;
  logic          ld_out_in, ld_out_sp, ld_sp;
  logic          take, push;

  assign in_ready_o  = !sp_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

  // Move words between the input, the spare slot and the output slot
  always_comb begin
    take      = out_ready_i || !out_v_q;
    push      = in_valid_i && !sp_v_q;
    out_v_d   = out_v_q;
    sp_v_d    = sp_v_q;
    ld_out_in = 1'b0;
    ld_out_sp = 1'b0;
    ld_sp     = 1'b0;
    if (take) begin
      if (sp_v_q) begin
        out_v_d   = 1'b1;
        sp_v_d    = 1'b0;
        ld_out_sp = 1'b1;
      end else begin
        out_v_d   = push;
        ld_out_in = push;
      end
    end else if (push) begin
      sp_v_d = 1'b1;
      ld_sp  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sp_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sp_v_q  <= sp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out_in) begin
      out_data_q <= in_data_i;
    end else if (ld_out_sp) begin
      out_data_q <= sp_data_q;
    end
    if (ld_sp) begin
      sp_data_q <= in_data_i;
    end
  end

endmodule

[hdl/rrr_core.sv]
module rrr_core import rrr_pkg::*; #(
  parameter int VOLUME_BITS = 40,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VOLUME_BITS-1:0] storage_i,
  input  logic [VOLUME_BITS-1:0] inflow_i,
  input  logic [VOLUME_BITS-1:0] demand_i,
  input  logic [VOLUME_BITS-1:0] capacity_i,
  input  logic [VOLUME_BITS-1:0] mean_inflow_i,
  input  logic [VOLUME_BITS-1:0] mean_demand_i,
  input  logic                   is_irrigation_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VOLUME_BITS+1:0] release_res_o,
  output logic                   saturated_o,
  output logic                   divide_by_zero_o
);

  localparam int V      = VOLUME_BITS;
  localparam int F      = FRAC_BITS;
  localparam int NL     = nlimbs(V + 1);
  localparam int PAD_W  = NL * LIMB_W;
  localparam int NUM_W  = 2 * V + 1;
  localparam int M_W    = 2 * F + 1;
  localparam int ACC_W  = 2 * F + V + 2;
  localparam int KMIN_I = ((1 << F) + 5) / 10;
  localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};
  localparam logic [F:0] KMIN  = (F+1)'(KMIN_I);

  // Stage map
  localparam int S_IN   = 0;
  localparam int S_PREP = 1;
  localparam int S_MUL1 = 2;
  localparam int S_DIV  = S_MUL1 + NL;
  localparam int S_SQ   = S_DIV + V + 1;
  localparam int S_W    = S_SQ + 1;
  localparam int S_MUL2 = S_W + 1;
  localparam int NST    = S_MUL2 + 2 * NL;

  typedef struct packed {
    logic [V-1:0]     s;
    logic [V-1:0]     inf;
    logic [V-1:0]     d;
    logic [V-1:0]     c;
    logic [V-1:0]     mi;
    logic [V-1:0]     md;
    logic             irr;
    logic [V:0]       ovf;
    logic [V-1:0]     tmp;
    logic             c_zero;
    logic             big_ratio;
    logic             use_sub;
    logic             md_zero;
    logic             dbz;
    logic [V:0]       psub;
    logic [PAD_W-1:0] e;
    logic [NUM_W-1:0] num;
    logic [V:0]       pr;
    logic [V:0]       pq;
    logic [V-1:0]     kr;
    logic [F:0]       kq;
    logic [V-1:0]     rrem;
    logic [F-1:0]     rq;
    logic [F:0]       k;
    logic [PAD_W-1:0] p;
    logic [2*F-1:0]   rr;
    logic [M_W-1:0]   m;
    logic [M_W-1:0]   n;
    logic [ACC_W-1:0] acc;
  } pipe_t;

  pipe_t            pipe_q [NST];
  pipe_t            pipe_d [NST];
  logic [NST-1:0]   valid_q;
  logic             en;

  assign en          = out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NST-1];

  // Capture the input word
  always_comb begin
    pipe_d[S_IN]     = '0;
    pipe_d[S_IN].s   = storage_i;
    pipe_d[S_IN].inf = inflow_i;
    pipe_d[S_IN].d   = demand_i;
    pipe_d[S_IN].c   = capacity_i;
    pipe_d[S_IN].mi  = mean_inflow_i;
    pipe_d[S_IN].md  = mean_demand_i;
    pipe_d[S_IN].irr = is_irrigation_i;
  end

  // Overflow, clipped storage, ratio and rule selection
  always_comb begin
    logic [V:0]   sum;
    logic [V+1:0] diff;
    logic         gt;
    sum  = {1'b0, pipe_q[S_PREP-1].s} + {1'b0, pipe_q[S_PREP-1].inf};
    diff = {1'b0, sum} - {2'b0, pipe_q[S_PREP-1].c};
    gt   = !diff[V+1] && (diff != '0);
    pipe_d[S_PREP]           = pipe_q[S_PREP-1];
    pipe_d[S_PREP].ovf       = gt ? diff[V:0] : '0;
    pipe_d[S_PREP].tmp       = gt ? pipe_q[S_PREP-1].c : sum[V-1:0];
    pipe_d[S_PREP].c_zero    = (pipe_q[S_PREP-1].c == '0);
    pipe_d[S_PREP].big_ratio = (pipe_q[S_PREP-1].mi == '0) ||
                             ({pipe_q[S_PREP-1].c, 1'b0} > {1'b0, pipe_q[S_PREP-1].mi});
    pipe_d[S_PREP].use_sub = ({pipe_q[S_PREP-1].md, 1'b0} < {1'b0, pipe_q[S_PREP-1].mi});
    pipe_d[S_PREP].md_zero = (pipe_q[S_PREP-1].md == '0);
    pipe_d[S_PREP].dbz     = (pipe_q[S_PREP-1].c == '0) ||
                             (pipe_q[S_PREP-1].irr &&
                              !({pipe_q[S_PREP-1].md, 1'b0} < {1'b0, pipe_q[S_PREP-1].mi}) &&
                              (pipe_q[S_PREP-1].md == '0));
    pipe_d[S_PREP].psub    = {1'b0, pipe_q[S_PREP-1].mi} + {1'b0, pipe_q[S_PREP-1].d}
                             - {1'b0, pipe_q[S_PREP-1].md};
    pipe_d[S_PREP].e       = PAD_W'({1'b0, pipe_q[S_PREP-1].md} + {1'b0, pipe_q[S_PREP-1].d});
    pipe_d[S_PREP].num     = '0;
  end

  // Mean inflow times (mean demand + demand), one slice per stage
  for (genvar j = 0; j < NL; j++) begin : g_mul1
    localparam int I = S_MUL1 + j;
    always_comb begin
      logic [V+LIMB_W-1:0] prod;
      prod       = pipe_q[I-1].mi * pipe_q[I-1].e[j*LIMB_W +: LIMB_W];
      pipe_d[I]     = pipe_q[I-1];
      pipe_d[I].num = pipe_q[I-1].num + (NUM_W'(prod) << (j * LIMB_W));
    end
  end

  // Restoring division: one quotient bit per stage for k, r and P
  for (genvar j = 0; j < V + 1; j++) begin : g_div
    localparam int I = S_DIV + j;
    logic [V:0]   pr_in, pq_in, pr_out;
    logic         pge;
    logic [V-1:0] kr_in, kr_out, rrem_in, rrem_out;
    logic [F:0]   kq_in;
    logic [F-1:0] rq_in;
    logic         kge, rge;

    if (j == 0) begin : g_init
      assign pr_in   = {1'b0, pipe_q[I-1].num[NUM_W-1 -: V]};
      assign pq_in   = pipe_q[I-1].num[V:0];
      assign kr_in   = (pipe_q[I-1].tmp == pipe_q[I-1].c) ? '0 : pipe_q[I-1].tmp;
      assign kq_in   = {{F{1'b0}}, (pipe_q[I-1].tmp == pipe_q[I-1].c)};
      assign rrem_in = pipe_q[I-1].c;
      assign rq_in   = '0;
    end else begin : g_next
      assign pr_in   = pipe_q[I-1].pr;
      assign pq_in   = pipe_q[I-1].pq;
      assign kr_in   = pipe_q[I-1].kr;
      assign kq_in   = pipe_q[I-1].kq;
      assign rrem_in = pipe_q[I-1].rrem;
      assign rq_in   = pipe_q[I-1].rq;
    end

    rrr_divstep #(.W(V + 1)) u_pdiv (
      .rem_i (pr_in),
      .bit_i (pq_in[V]),
      .den_i ({pipe_q[I-1].md, 1'b0}),
      .rem_o (pr_out),
      .q_o   (pge)
    );

    rrr_divstep #(.W(V)) u_kdiv (
      .rem_i (kr_in),
      .bit_i (1'b0),
      .den_i (pipe_q[I-1].c),
      .rem_o (kr_out),
      .q_o   (kge)
    );

    rrr_divstep #(.W(V)) u_rdiv (
      .rem_i (rrem_in),
      .bit_i (1'b0),
      .den_i (pipe_q[I-1].mi),
      .rem_o (rrem_out),
      .q_o   (rge)
    );

    always_comb begin
      pipe_d[I]    = pipe_q[I-1];
      pipe_d[I].pr = pr_out;
      pipe_d[I].pq = {pq_in[V-1:0], pge};
      if (j < F) begin
        pipe_d[I].kr   = kr_out;
        pipe_d[I].kq   = {kq_in[F-1:0], kge};
        pipe_d[I].rrem = rrem_out;
        pipe_d[I].rq   = {rq_in[F-2:0], rge};
      end
    end
  end

  // Square the ratio, clamp k, pick the provisional release
  always_comb begin
    pipe_d[S_SQ]    = pipe_q[S_SQ-1];
    pipe_d[S_SQ].rr = pipe_q[S_SQ-1].rq * pipe_q[S_SQ-1].rq;
    if (pipe_q[S_SQ-1].c_zero) begin
      pipe_d[S_SQ].k = ONE_Q;
    end else if (pipe_q[S_SQ-1].kq < KMIN) begin
      pipe_d[S_SQ].k = KMIN;
    end else if (pipe_q[S_SQ-1].kq > ONE_Q) begin
      pipe_d[S_SQ].k = ONE_Q;
    end else begin
      pipe_d[S_SQ].k = pipe_q[S_SQ-1].kq;
    end
    if (!pipe_q[S_SQ-1].irr) begin
      pipe_d[S_SQ].p = PAD_W'(pipe_q[S_SQ-1].mi);
    end else if (pipe_q[S_SQ-1].use_sub) begin
      pipe_d[S_SQ].p = PAD_W'(pipe_q[S_SQ-1].psub);
    end else if (pipe_q[S_SQ-1].md_zero) begin
      pipe_d[S_SQ].p = '0;
    end else begin
      pipe_d[S_SQ].p = PAD_W'(pipe_q[S_SQ-1].pq);
    end
  end

  // Weights: k for a large ratio, 4r^2*k and (1-4r^2) otherwise
  always_comb begin
    logic [F+1:0]   w_raw;
    logic [F:0]     w;
    logic [2*F+1:0] wk;
    w_raw = pipe_q[S_W-1].rr[2*F-1 : F-2];
    w     = (w_raw > (F+2)'(ONE_Q)) ? ONE_Q : w_raw[F:0];
    wk    = w * pipe_q[S_W-1].k;
    pipe_d[S_W]     = pipe_q[S_W-1];
    pipe_d[S_W].m   = pipe_q[S_W-1].big_ratio ? {pipe_q[S_W-1].k, {F{1'b0}}} : wk[M_W-1:0];
    pipe_d[S_W].n   = pipe_q[S_W-1].big_ratio ? '0 : {ONE_Q - w, {F{1'b0}}};
    pipe_d[S_W].acc = '0;
  end

  // Accumulate m*P + n*inflow, one slice product per stage
  for (genvar j = 0; j < 2 * NL; j++) begin : g_mul2
    localparam int I   = S_MUL2 + j;
    localparam int OFS = (j < NL) ? j : j - NL;
    always_comb begin
      logic [M_W+LIMB_W-1:0] prod;
      logic [PAD_W-1:0]      infpad;
      infpad = PAD_W'(pipe_q[I-1].inf);
      if (j < NL) begin
        prod = pipe_q[I-1].m * pipe_q[I-1].p[OFS*LIMB_W +: LIMB_W];
      end else begin
        prod = pipe_q[I-1].n * infpad[OFS*LIMB_W +: LIMB_W];
      end
      pipe_d[I]     = pipe_q[I-1];
      pipe_d[I].acc = pipe_q[I-1].acc + (ACC_W'(prod) << (OFS * LIMB_W));
    end
  end

  // Drop the fraction, add overflow, saturate
  always_comb begin
    logic [V+1:0] rel;
    logic [V+2:0] total;
    rel              = pipe_q[NST-1].acc[ACC_W-1 : 2*F];
    total            = (V+3)'(rel) + (V+3)'(pipe_q[NST-1].ovf);
    saturated_o      = total[V+2];
    release_res_o    = total[V+2] ? '1 : total[V+1:0];
    divide_by_zero_o = pipe_q[NST-1].dbz;
  end

  // Advance all stages together while the output side has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= pipe_d;
    end
  end

endmodule

[hdl/reservoir_release_rule.sv]
// Reservoir release rule, one reservoir record per word.
// Input channel item_i carries storage, inflow, demand, capacity, mean
// inflow, mean demand and the irrigation flag; output channel res_o carries
// the total release (overflow included), a saturation flag and a
// divide-by-zero flag. Both use valid/ready; a word moves when both are high.
// Throughput: one word per cycle while the output buffer has room. The pipeline
// depth is set by the divider, which resolves one quotient bit per stage for
// the irrigation release, and by the wide products, which are built from
// 16-bit slices one per stage.
// Every word gives exactly one result, in order.
// Reset clears all valid bits; the pipeline is empty and ready right away.
// When res_o stalls, a two-entry output buffer takes one more word, then
// item_i.ready drops and the whole pipeline holds until res_o drains.
module reservoir_release_rule #(
  parameter int VOLUME_BITS = 40,
  parameter int FRAC_BITS   = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rrr_in_if.sink   item_i,
  rrr_out_if.source res_o
);

  localparam int DW = VOLUME_BITS + 4;

  logic                   core_valid, core_ready;
  logic [VOLUME_BITS+1:0] core_release;
  logic                   core_sat, core_dbz;
  logic [DW-1:0]          out_data;

  rrr_core #(
    .VOLUME_BITS (VOLUME_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (item_i.valid),
    .in_ready_o       (item_i.ready),
    .storage_i        (item_i.storage),
    .inflow_i         (item_i.inflow),
    .demand_i         (item_i.demand),
    .capacity_i       (item_i.capacity),
    .mean_inflow_i    (item_i.mean_inflow),
    .mean_demand_i    (item_i.mean_demand),
    .is_irrigation_i  (item_i.is_irrigation),
    .out_valid_o      (core_valid),
    .out_ready_i      (core_ready),
    .release_res_o    (core_release),
    .saturated_o      (core_sat),
    .divide_by_zero_o (core_dbz)
  );

  rrr_skid #(
    .DW (DW)
  ) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (core_valid),
    .in_data_i   ({core_release, core_sat, core_dbz}),
    .in_ready_o  (core_ready),
    .out_valid_o (res_o.valid),
    .out_data_o  (out_data),
    .out_ready_i (res_o.ready)
  );

  // Split the buffered word onto the result fields
  assign res_o.release_res    = out_data[DW-1:2];
  assign res_o.saturated      = out_data[1];
  assign res_o.divide_by_zero = out_data[0];

endmodule

[hdl/rrr_checker.sv]
module rrr_checker #(
  parameter int RW = 42
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [RW-1:0] release_i,
  input logic          saturated_i,
  input logic          dbz_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(release_i) && $stable(saturated_i) && $stable(dbz_i))
    else $error("stalled result changed");

  // Saturation pins the release at full scale
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> release_i == {RW{1'b1}})
    else $error("saturated result below full scale");

  // Input backpressure only comes from a full output buffer
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

endmodule

bind reservoir_release_rule rrr_checker #(
  .RW (VOLUME_BITS + 2)
) u_rrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .release_i   (res_o.release_res),
  .saturated_i (res_o.saturated),
  .dbz_i       (res_o.divide_by_zero)
);

[tb/tb_reservoir_release_rule.sv]
`timescale 1ns / 100ps

module tb_reservoir_release_rule;

  localparam int VB = 40;
  localparam int FB = 16;
  localparam int OB = VB + 2;
  localparam int LATENCY = 54;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [127:0] ONE_Q = 128'd1 << FB;
  localparam logic [127:0] KMIN = (ONE_Q + 128'd5) / 128'd10;
  localparam logic [127:0] OUT_MAX = (128'd1 << OB) - 128'd1;

  typedef struct packed {
    logic [VB-1:0] storage;
    logic [VB-1:0] inflow;
    logic [VB-1:0] demand;
    logic [VB-1:0] capacity;
    logic [VB-1:0] mean_inflow;
    logic [VB-1:0] mean_demand;
    logic          is_irrigation;
  } reservoir_t;

  typedef struct packed {
    logic [OB-1:0] release_res;
    logic          saturated;
    logic          divide_by_zero;
  } release_t;

  logic clk_i;
  logic rst_ni;

  rrr_in_if  #(.VOLUME_BITS(VB)) item_bus ();
  rrr_out_if #(.VOLUME_BITS(VB)) res_bus ();

  reservoir_release_rule #(.VOLUME_BITS(VB), .FRAC_BITS(FB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_bus.sink),
    .res_o  (res_bus.source)
  );

  release_t expected_releases[$];
  int       mismatches;
  int       idle_cycles;
  bit       hold_off;
  bit       timed_out;

  // Compute the expected release for one reservoir record.
  function automatic release_t predict_release(reservoir_t r);
    logic [127:0] s, inf, d, c, mi, md;
    logic [127:0] sum, ovf, tmp, k, p, rel, total, ratio, w;
    release_t res;
    s = 128'(r.storage); inf = 128'(r.inflow); d = 128'(r.demand);
    c = 128'(r.capacity); mi = 128'(r.mean_inflow); md = 128'(r.mean_demand);
    res = '0;
    sum = s + inf;
    ovf = (sum > c) ? sum - c : '0;
    tmp = (sum < c) ? sum : c;
    if (c == '0) begin
      res.divide_by_zero = 1'b1;
      k = ONE_Q;
    end else begin
      k = (tmp << FB) / c;
      if (k < KMIN) k = KMIN;
      if (k > ONE_Q) k = ONE_Q;
    end
    if (!r.is_irrigation) begin
      p = mi;
    end else if (2 * md < mi) begin
      p = mi + d - md;
    end else if (md == '0) begin
      res.divide_by_zero = 1'b1;
      p = '0;
    end else begin
      p = (mi * (md + d)) / (2 * md);
    end
    if (mi == '0 || 2 * c > mi) begin
      rel = (k * p) >> FB;
    end else begin
      ratio = (c << FB) / mi;
      w = (4 * ratio * ratio) >> FB;
      if (w > ONE_Q) w = ONE_Q;
      rel = (w * k * p + (((ONE_Q - w) << FB) * inf)) >> (2 * FB);
    end
    total = rel + ovf;
    if (total > OUT_MAX) begin
      total = OUT_MAX;
      res.saturated = 1'b1;
    end
    res.release_res = total[OB-1:0];
    return res;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stall pattern, plus a long hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) res_bus.ready <= 1'b0;
      else res_bus.ready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 3) == 0);
    end
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    release_t got, exp_r;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got.release_res    = res_bus.release_res;
      got.saturated      = res_bus.saturated;
      got.divide_by_zero = res_bus.divide_by_zero;
      if (expected_releases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: release %0d", got.release_res);
      end else begin
        exp_r = expected_releases.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rel %0d sat %0b dbz %0b, got rel %0d sat %0b dbz %0b",
                     exp_r.release_res, exp_r.saturated, exp_r.divide_by_zero,
                     got.release_res, got.saturated, got.divide_by_zero);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("status: fail");
      $finish;
    end
  end

  // Send one word and record its expected release
  task automatic send_record(reservoir_t r);
    item_bus.valid         <= 1'b1;
    item_bus.storage       <= r.storage;
    item_bus.inflow        <= r.inflow;
    item_bus.demand        <= r.demand;
    item_bus.capacity      <= r.capacity;
    item_bus.mean_inflow   <= r.mean_inflow;
    item_bus.mean_demand   <= r.mean_demand;
    item_bus.is_irrigation <= r.is_irrigation;
    do @(posedge clk_i); while (!item_bus.ready);
    expected_releases.push_back(predict_release(r));
  endtask

  task automatic idle_gap(int n);
    item_bus.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [VB-1:0] rand_volume();
    logic [VB-1:0] v;
    v = VB'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return v >> $urandom_range(0, VB - 1);
      3: return VB'($urandom_range(0, 20));
      default: return v;
    endcase
  endfunction

  function automatic reservoir_t rand_record();
    reservoir_t r;
    r.storage       = rand_volume();
    r.inflow        = rand_volume();
    r.demand        = rand_volume();
    r.capacity      = rand_volume();
    r.mean_inflow   = rand_volume();
    r.mean_demand   = rand_volume();
    r.is_irrigation = 1'($urandom_range(0, 1));
    // Bias toward small capacity ratios so the blended rule is exercised
    if ($urandom_range(0, 3) == 0) r.capacity = r.mean_inflow >> $urandom_range(1, 12);
    return r;
  endfunction

  function automatic reservoir_t make_record(logic [VB-1:0] s, logic [VB-1:0] inf,
      logic [VB-1:0] d, logic [VB-1:0] c, logic [VB-1:0] mi, logic [VB-1:0] md,
      logic irr);
    reservoir_t r;
    r.storage = s; r.inflow = inf; r.demand = d; r.capacity = c;
    r.mean_inflow = mi; r.mean_demand = md; r.is_irrigation = irr;
    return r;
  endfunction

  // Directed corners: extremes, each rule branch, zero divisors
  task automatic test_directed();
    logic [VB-1:0] mx;
    mx = '1;
    send_record(make_record(0, 0, 0, 0, 0, 0, 0));
    send_record(make_record(0, 0, 0, 0, 0, 0, 1));
    send_record(make_record(mx, mx, mx, mx, mx, mx, 0));
    send_record(make_record(mx, mx, mx, mx, mx, mx, 1));
    send_record(make_record(mx, mx, mx, 0, mx, mx, 1));
    send_record(make_record(100, 50, 30, 0, 1000, 10, 1));
    send_record(make_record(100, 50, 30, 0, 0, 0, 1));
    send_record(make_record(10, 5, 40, 1000, 0, 0, 1));
    send_record(make_record(500, 200, 300, 1000, 800, 100, 1));
    send_record(make_record(500, 200, 300, 1000, 800, 600, 1));
    send_record(make_record(500, 200, 300, 100, 8000, 600, 1));
    send_record(make_record(500, 200, 300, 100, 8000, 600, 0));
    send_record(make_record(0, 1, 0, 1000000, 5000, 0, 0));
    send_record(make_record(mx, mx, 0, 1, mx, 0, 1));
    send_record(make_record(mx, 0, mx, mx >> 1, mx, mx >> 1, 1));
    send_record(make_record(1, 1, 1, 1, 1, 1, 1));
    send_record(make_record(300, 0, 7, 2000, 4000, 1, 1));
    send_record(make_record(mx, mx, mx, 1, mx, 1, 1));
    send_record(make_record(40'hAAAAAAAAAA, 40'h5555555555, 40'hAAAAAAAAAA,
                            40'h5555555555, 40'hAAAAAAAAAA, 40'h5555555555, 0));
    send_record(make_record(40'h5555555555, 40'hAAAAAAAAAA, 40'h5555555555,
                            40'hAAAAAAAAAA, 40'h5555555555, 40'hAAAAAAAAAA, 1));
    idle_gap(1);
  endtask

  // Random records sent in bursts with random gaps
  task automatic test_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_record(rand_record());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    idle_gap(1);
  endtask

  // Stall the receiver long enough that the pipeline fills and input backs up
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (LATENCY * 3) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (150) send_record(rand_record());
        idle_gap(1);
      end
    join
  endtask

  initial begin
    int drain;
    mismatches = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    timed_out = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.storage = '0;
    item_bus.inflow = '0;
    item_bus.demand = '0;
    item_bus.capacity = '0;
    item_bus.mean_inflow = '0;
    item_bus.mean_demand = '0;
    item_bus.is_irrigation = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(1550);

    drain = 0;
    while (expected_releases.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_releases.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rrr_pkg.sv
hdl/rrr_if.sv
hdl/rrr_divstep.sv
hdl/rrr_skid.sv
hdl/rrr_core.sv
hdl/reservoir_release_rule.sv
hdl/rrr_checker.sv
tb/tb_reservoir_release_rule.sv
